// ===== hw/rtl/swts_pkg.sv =====
package swts_pkg;

  // Ring geometry.
  localparam int unsigned HistDepth = 64;
  localparam int unsigned IdxW      = (HistDepth > 1) ? $clog2(HistDepth) : 1;
  localparam int unsigned CntW      = $clog2(HistDepth + 1);

  // Field widths.
  localparam int unsigned BytesW = 48;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned RateW  = 56;
  localparam int unsigned MeanW  = 56;
  localparam int unsigned MedW   = 49;

  // Accumulator and divider widths.
  localparam int unsigned SumW   = BytesW + IdxW;
  localparam int unsigned DsumW  = TimeW + IdxW;
  localparam int unsigned UsW    = 20;
  localparam int unsigned HalfW  = SumW / 2;
  localparam int unsigned DivdW  = SumW + UsW;
  localparam int unsigned DivsW  = DsumW;

  localparam logic [UsW-1:0]   UsPerSecond  = UsW'(1000000);
  localparam logic [TimeW-1:0] TickReset    = TimeW'(1000000);
  localparam logic [IdxW-1:0]  LastSlot     = IdxW'(HistDepth - 1);

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ST_RD,
    S_ST_USE,
    S_RT_RD,
    S_RT_USE,
    S_MUL_LO,
    S_MUL_HI,
    S_RDIV_GO,
    S_RDIV_WAIT,
    S_MED_INIT,
    S_MO_RD,
    S_MO_USE,
    S_MI_RD,
    S_MI_USE,
    S_MDIV_GO,
    S_MDIV_WAIT
  } state_e;

  // Wrapping slot arithmetic.
  function automatic logic [IdxW-1:0] slot_inc(input logic [IdxW-1:0] idx);
    return (idx == LastSlot) ? '0 : idx + IdxW'(1);
  endfunction

  function automatic logic [IdxW-1:0] slot_dec(input logic [IdxW-1:0] idx);
    return (idx == '0) ? LastSlot : idx - IdxW'(1);
  endfunction

endpackage

// ===== hw/rtl/swts_in_if.sv =====
interface swts_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [31:0] byte_count;
  logic [31:0] elapsed_us;
  logic [31:0] window_us;
  logic       skip_zeroes;

  modport source (output valid, cmd, byte_count, elapsed_us, window_us, skip_zeroes,
                  input ready);
  modport sink   (input valid, cmd, byte_count, elapsed_us, window_us, skip_zeroes,
                  output ready);
endinterface

// ===== hw/rtl/swts_out_if.sv =====
interface swts_out_if;
  logic        valid;
  logic        ready;
  logic [55:0] rate_bps;
  logic [47:0] max_bytes;
  logic [47:0] min_bytes;
  logic [55:0] mean_q8;
  logic [48:0] median_x2;

  modport source (output valid, rate_bps, max_bytes, min_bytes, mean_q8, median_x2,
                  input ready);
  modport sink   (input valid, rate_bps, max_bytes, min_bytes, mean_q8, median_x2,
                  output ready);
endinterface

// ===== hw/rtl/swts_div.sv =====
// Restoring divider, one quotient bit per cycle.
module swts_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [swts_pkg::DivdW-1:0]   dividend_i,
  input  logic [swts_pkg::DivsW-1:0]   divisor_i,
  output logic                         done_o,
  output logic [swts_pkg::DivdW-1:0]   quotient_o
);

  localparam int unsigned CW = $clog2(swts_pkg::DivdW + 1);

  logic                        busy_q;
  logic                        done_q;
  logic [CW-1:0]               cnt_q;
  logic [swts_pkg::DivsW:0]    rem_q;
  logic [swts_pkg::DivsW:0]    rem_sh;
  logic [swts_pkg::DivsW:0]    rem_d;
  logic                        qbit;
  logic [swts_pkg::DivdW-1:0]  quo_q;
  logic [swts_pkg::DivsW-1:0]  dvs_q;

  // One shift and trial subtract.
  always_comb begin
    rem_sh = {rem_q[swts_pkg::DivsW-1:0], quo_q[swts_pkg::DivdW-1]};
    qbit   = (rem_sh >= {1'b0, dvs_q});
    rem_d  = qbit ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
  end

  // Control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(swts_pkg::DivdW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[swts_pkg::DivdW-2:0], qbit};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== hw/rtl/sliding_window_traffic_stats.sv =====
// Add and tick transactions are accepted one per cycle while no query is in progress.
// A query walks the ring through the bucket memories: a statistics scan, a rate
// walk and rate division (both skipped when the window is zero), a median count
// and a final mean division, run one after another.
// Reset is asynchronous: head, per-entry valid bits and interval are reset at once,
// so there is no clearing pass and memory entries read as zero until written.
module sliding_window_traffic_stats (
  input  logic              clk_i,
  input  logic              rst_ni,
  swts_in_if.sink           in_i,
  swts_out_if.source        out_o,
  input  logic              cfg_we_i,
  input  logic [31:0]       cfg_wdata_i
);

  localparam int unsigned IW = swts_pkg::IdxW;
  localparam int unsigned CW = swts_pkg::CntW;

  // Bucket memories and valid bits.
  logic [swts_pkg::BytesW-1:0] bytes_mem [swts_pkg::HistDepth];
  logic [swts_pkg::TimeW-1:0]  time_mem  [swts_pkg::HistDepth];
  logic [swts_pkg::HistDepth-1:0] valid_q;
  logic [swts_pkg::BytesW-1:0] rd_bytes_q;
  logic [swts_pkg::TimeW-1:0]  rd_time_q;
  logic                        rd_valid_q;
  logic [swts_pkg::BytesW-1:0] rd_bytes;
  logic [swts_pkg::TimeW-1:0]  rd_time;
  logic [IW-1:0]               rd_addr;
  logic                        mem_we;

  // Control state.
  swts_pkg::state_e            state_q, state_d;
  logic [IW-1:0]               head_q;
  logic [swts_pkg::BytesW-1:0] head_bytes_q;
  logic [swts_pkg::TimeW-1:0]  interval_q;
  logic                        out_valid_q;

  // Query datapath.
  logic [swts_pkg::TimeW-1:0]  window_q;
  logic                        skip_q;
  logic [IW-1:0]               idx_q;
  logic [IW-1:0]               jdx_q;
  logic [CW-1:0]               n_q;
  logic [swts_pkg::SumW-1:0]   sum_q;
  logic [swts_pkg::BytesW-1:0] max_q;
  logic [swts_pkg::BytesW-1:0] min_q;
  logic [swts_pkg::SumW-1:0]   rsum_q;
  logic [swts_pkg::DsumW-1:0]  dsum_q;
  logic [CW-1:0]               taken_q;
  logic [swts_pkg::HalfW+swts_pkg::UsW-1:0]                 prod_lo_q;
  logic [swts_pkg::SumW-swts_pkg::HalfW+swts_pkg::UsW-1:0]  prod_hi_q;
  logic [swts_pkg::RateW-1:0]  rate_q;
  logic [swts_pkg::BytesW-1:0] cand_q;
  logic [CW-1:0]               less_q;
  logic [CW-1:0]               leq_q;
  logic [swts_pkg::BytesW-1:0] m1_q;
  logic [swts_pkg::BytesW-1:0] m2_q;

  logic                        in_acc;
  logic                        out_free;
  logic                        div_start;
  logic                        div_done;
  logic [swts_pkg::DivdW-1:0]  div_dividend;
  logic [swts_pkg::DivsW-1:0]  div_divisor;
  logic [swts_pkg::DivdW-1:0]  div_quo;

  logic [swts_pkg::BytesW:0]   add_sum;
  logic [swts_pkg::TimeW-1:0]  tick_time;
  logic                        idx_last;
  logic                        jdx_last;
  logic                        q_idx;
  logic                        q_jdx;
  logic                        rt_is_head;
  logic [swts_pkg::BytesW-1:0] rt_bytes;
  logic [swts_pkg::TimeW-1:0]  rt_time;
  logic [swts_pkg::DsumW-1:0]  dsum_nx;
  logic                        rt_stop;
  logic [CW-1:0]               less_nx;
  logic [CW-1:0]               leq_nx;
  logic [CW-1:0]               k1;
  logic [CW-1:0]               k2;
  logic [swts_pkg::DsumW-1:0]  win_ext;

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  // Memory read data; an entry never written reads as zero.
  assign rd_bytes = rd_valid_q ? rd_bytes_q : '0;
  assign rd_time  = rd_valid_q ? rd_time_q  : '0;

  // Entry qualification for the statistics.
  assign q_idx = (idx_q != head_q) && !(skip_q && (rd_bytes == '0));
  assign q_jdx = (jdx_q != head_q) && !(skip_q && (rd_bytes == '0));
  assign idx_last = (idx_q == swts_pkg::LastSlot);
  assign jdx_last = (jdx_q == swts_pkg::LastSlot);

  // Head bucket update terms.
  assign add_sum   = {1'b0, head_bytes_q} + (swts_pkg::BytesW+1)'(in_i.byte_count);
  assign tick_time = (in_i.elapsed_us != '0) ? in_i.elapsed_us : interval_q;

  // Rate walk step; the head bucket comes from its register, its duration the tick interval.
  assign win_ext    = swts_pkg::DsumW'(window_q);
  assign rt_is_head = (idx_q == head_q);
  assign rt_bytes   = rt_is_head ? head_bytes_q : rd_bytes;
  assign rt_time    = (!rt_is_head && (rd_time != '0)) ? rd_time : interval_q;
  assign dsum_nx    = dsum_q + swts_pkg::DsumW'(rt_time);
  assign rt_stop    = (dsum_nx >= win_ext) || (taken_q == CW'(swts_pkg::HistDepth - 1));

  // Median rank counting.
  assign less_nx = (q_jdx && (rd_bytes < cand_q))  ? less_q + CW'(1) : less_q;
  assign leq_nx  = (q_jdx && (rd_bytes <= cand_q)) ? leq_q + CW'(1)  : leq_q;
  assign k1      = (n_q - CW'(1)) >> 1;
  assign k2      = n_q >> 1;

  // Memory write port and read port.
  assign mem_we  = in_acc && (in_i.cmd == swts_pkg::CMD_TICK);
  assign rd_addr = (state_q == swts_pkg::S_MI_RD) ? jdx_q : idx_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bytes_mem[head_q] <= head_bytes_q;
      time_mem[head_q]  <= tick_time;
    end
    rd_bytes_q <= bytes_mem[rd_addr];
    rd_time_q  <= time_mem[rd_addr];
  end

  // Head, valid bits, interval and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      rd_valid_q   <= 1'b0;
      head_q       <= '0;
      head_bytes_q <= '0;
      interval_q   <= swts_pkg::TickReset;
      out_valid_q  <= 1'b0;
      state_q      <= swts_pkg::S_IDLE;
    end else begin
      state_q    <= state_d;
      rd_valid_q <= valid_q[rd_addr];
      if (cfg_we_i) begin
        interval_q <= cfg_wdata_i;
      end
      if (in_acc && (in_i.cmd == swts_pkg::CMD_ADD)) begin
        head_bytes_q <= add_sum[swts_pkg::BytesW] ? '1 : add_sum[swts_pkg::BytesW-1:0];
      end
      if (mem_we) begin
        valid_q[head_q] <= 1'b1;
        head_q          <= swts_pkg::slot_inc(head_q);
        head_bytes_q    <= '0;
      end
      if (state_q == swts_pkg::S_MDIV_WAIT && div_done) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      swts_pkg::S_IDLE: begin
        if (in_acc && (in_i.cmd == swts_pkg::CMD_QUERY)) state_d = swts_pkg::S_ST_RD;
      end
      swts_pkg::S_ST_RD:  state_d = swts_pkg::S_ST_USE;
      swts_pkg::S_ST_USE: begin
        if (!idx_last)            state_d = swts_pkg::S_ST_RD;
        else if (window_q == '0)  state_d = swts_pkg::S_MED_INIT;
        else                      state_d = swts_pkg::S_RT_RD;
      end
      swts_pkg::S_RT_RD:  state_d = swts_pkg::S_RT_USE;
      swts_pkg::S_RT_USE: state_d = rt_stop ? swts_pkg::S_MUL_LO : swts_pkg::S_RT_RD;
      swts_pkg::S_MUL_LO: state_d = swts_pkg::S_MUL_HI;
      swts_pkg::S_MUL_HI: state_d = swts_pkg::S_RDIV_GO;
      swts_pkg::S_RDIV_GO: state_d = swts_pkg::S_RDIV_WAIT;
      swts_pkg::S_RDIV_WAIT: begin
        if (div_done) state_d = swts_pkg::S_MED_INIT;
      end
      swts_pkg::S_MED_INIT: begin
        // With no qualifying bucket max, min, mean and median stay zero; the divider still
        // runs to keep one completion path, its result being discarded.
        state_d = (n_q == '0) ? swts_pkg::S_MDIV_GO : swts_pkg::S_MO_RD;
      end
      swts_pkg::S_MO_RD:  state_d = swts_pkg::S_MO_USE;
      swts_pkg::S_MO_USE: begin
        if (q_idx)         state_d = swts_pkg::S_MI_RD;
        else if (idx_last) state_d = swts_pkg::S_MDIV_GO;
        else               state_d = swts_pkg::S_MO_RD;
      end
      swts_pkg::S_MI_RD:  state_d = swts_pkg::S_MI_USE;
      swts_pkg::S_MI_USE: begin
        if (!jdx_last)     state_d = swts_pkg::S_MI_RD;
        else if (idx_last) state_d = swts_pkg::S_MDIV_GO;
        else               state_d = swts_pkg::S_MO_RD;
      end
      swts_pkg::S_MDIV_GO: begin
        if (out_free) state_d = swts_pkg::S_MDIV_WAIT;
      end
      swts_pkg::S_MDIV_WAIT: begin
        if (div_done) state_d = swts_pkg::S_IDLE;
      end
      default: state_d = swts_pkg::S_IDLE;
    endcase
  end

  // Control outputs. The mean division starts only once the output slot is
  // free, so the result always lands in an empty register.
  always_comb begin
    in_i.ready   = (state_q == swts_pkg::S_IDLE);
    div_start    = (state_q == swts_pkg::S_RDIV_GO) ||
                   ((state_q == swts_pkg::S_MDIV_GO) && out_free);
    if (state_q == swts_pkg::S_RDIV_GO) begin
      div_dividend = (swts_pkg::DivdW'(prod_hi_q) << swts_pkg::HalfW) +
                     swts_pkg::DivdW'(prod_lo_q);
      div_divisor  = (win_ext > dsum_q) ? win_ext : dsum_q;
    end else begin
      div_dividend = swts_pkg::DivdW'({sum_q, 8'd0});
      div_divisor  = (n_q == '0) ? swts_pkg::DivsW'(1) : swts_pkg::DivsW'(n_q);
    end
  end

  // Query datapath.
  always_ff @(posedge clk_i) begin
    case (state_q)
      swts_pkg::S_IDLE: begin
        window_q <= in_i.window_us;
        skip_q   <= in_i.skip_zeroes;
        idx_q    <= '0;
        n_q      <= '0;
        sum_q    <= '0;
        max_q    <= '0;
        min_q    <= '0;
        m1_q     <= '0;
        m2_q     <= '0;
        rate_q   <= '0;
      end
      swts_pkg::S_ST_USE: begin
        if (q_idx) begin
          if ((n_q == '0) || (rd_bytes > max_q)) max_q <= rd_bytes;
          if ((n_q == '0) || (rd_bytes < min_q)) min_q <= rd_bytes;
          sum_q <= sum_q + swts_pkg::SumW'(rd_bytes);
          n_q   <= n_q + CW'(1);
        end
        if (idx_last) begin
          idx_q   <= swts_pkg::slot_dec(head_q);
          rsum_q  <= '0;
          dsum_q  <= '0;
          taken_q <= '0;
        end else begin
          idx_q <= idx_q + IW'(1);
        end
      end
      swts_pkg::S_RT_USE: begin
        rsum_q  <= rsum_q + swts_pkg::SumW'(rt_bytes);
        dsum_q  <= dsum_nx;
        taken_q <= taken_q + CW'(1);
        idx_q   <= swts_pkg::slot_dec(idx_q);
      end
      swts_pkg::S_MUL_LO: begin
        prod_lo_q <= (swts_pkg::HalfW+swts_pkg::UsW)'(rsum_q[swts_pkg::HalfW-1:0]) *
                     (swts_pkg::HalfW+swts_pkg::UsW)'(swts_pkg::UsPerSecond);
      end
      swts_pkg::S_MUL_HI: begin
        prod_hi_q <= (swts_pkg::SumW-swts_pkg::HalfW+swts_pkg::UsW)'(
                       rsum_q[swts_pkg::SumW-1:swts_pkg::HalfW]) *
                     (swts_pkg::SumW-swts_pkg::HalfW+swts_pkg::UsW)'(swts_pkg::UsPerSecond);
      end
      swts_pkg::S_RDIV_WAIT: begin
        if (div_done) begin
          rate_q <= (div_quo[swts_pkg::DivdW-1:swts_pkg::RateW] != '0) ? '1 :
                    div_quo[swts_pkg::RateW-1:0];
        end
      end
      swts_pkg::S_MED_INIT: begin
        idx_q <= '0;
      end
      swts_pkg::S_MO_USE: begin
        cand_q <= rd_bytes;
        jdx_q  <= '0;
        less_q <= '0;
        leq_q  <= '0;
        if (!q_idx) idx_q <= idx_q + IW'(1);
      end
      swts_pkg::S_MI_USE: begin
        less_q <= less_nx;
        leq_q  <= leq_nx;
        jdx_q  <= jdx_q + IW'(1);
        if (jdx_last) begin
          if ((less_nx <= k1) && (k1 < leq_nx)) m1_q <= cand_q;
          if ((less_nx <= k2) && (k2 < leq_nx)) m2_q <= cand_q;
          idx_q <= idx_q + IW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (state_q == swts_pkg::S_MDIV_WAIT && div_done) begin
      out_o.rate_bps  <= rate_q;
      out_o.max_bytes <= max_q;
      out_o.min_bytes <= min_q;
      out_o.mean_q8   <= (n_q == '0) ? '0 : div_quo[swts_pkg::MeanW-1:0];
      out_o.median_x2 <= swts_pkg::MedW'(m1_q) + swts_pkg::MedW'(m2_q);
    end
  end

  assign out_o.valid = out_valid_q;

  swts_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // A tick advances the head by one slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> (head_q == swts_pkg::slot_inc($past(head_q))))
    else $error("head did not advance on tick");

  // The memories are never written while a query walks them.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != swts_pkg::S_IDLE) |-> !mem_we)
    else $error("memory write during query");

  // A division completes only in a state that waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> ((state_q == swts_pkg::S_RDIV_WAIT) || (state_q == swts_pkg::S_MDIV_WAIT)))
    else $error("divider result not expected");

  // The mean division only starts into a free result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == swts_pkg::S_MDIV_WAIT) |-> !out_valid_q)
    else $error("result register busy during final division");

endmodule

// ===== tb/sv/tb_sliding_window_traffic_stats.sv =====
module tb_sliding_window_traffic_stats;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]       CmdUnused  = 2'd3;
  localparam int unsigned      Depth      = 64;
  localparam logic [47:0]      BytesMax   = 48'hFFFF_FFFF_FFFF;
  localparam logic [55:0]      RateMax    = 56'hFF_FFFF_FFFF_FFFF;
  localparam longint unsigned  CycleLimit = 3000000;
  localparam int unsigned      IdlePct    = 35;

  typedef struct packed {
    logic [55:0] rate_bps;
    logic [47:0] max_bytes;
    logic [47:0] min_bytes;
    logic [55:0] mean_q8;
    logic [48:0] median_x2;
  } stats_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [31:0] cfg_wdata_i;

  swts_in_if  in_if ();
  swts_out_if out_if ();

  sliding_window_traffic_stats i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Predictor state, mirrored from the meter.
  logic [47:0] ring_bytes [Depth];
  logic [31:0] ring_time  [Depth];
  logic [5:0]  head;
  logic [31:0] interval;

  stats_t      pending_stats[$];
  int unsigned mismatches;
  int unsigned queries_sent;
  int unsigned stats_checked;
  int unsigned items_sent;
  longint unsigned cycles;
  bit          no_idle;
  int unsigned hold_cycles;

  // Clock generation.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Cycle counter and timeout.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results pending", cycles, pending_stats.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] resolve_time(logic [31:0] t);
    return (t != 0) ? t : interval;
  endfunction

  // Expected statistics of a query over the current ring.
  function automatic stats_t compute_stats(logic [31:0] win, logic skip);
    stats_t          res;
    longint unsigned vals[$];
    longint unsigned sum, dsum, bsum, d, q, r, hi, lo, n;
    logic [5:0]      idx;
    sum = 0;
    for (int i = 0; i < Depth; i++) begin
      if (i == head || (skip && ring_bytes[i] == 0)) continue;
      vals.insert(vals.size(), ring_bytes[i]);
      sum += ring_bytes[i];
    end
    vals.sort();
    n = vals.size();
    res = '0;
    if (n != 0) begin
      res.min_bytes = 48'(vals[0]);
      res.max_bytes = 48'(vals[n-1]);
      res.mean_q8   = 56'((sum / n) * 256 + ((sum % n) * 256) / n);
      if (n % 2 == 1) res.median_x2 = 49'(vals[n/2] * 2);
      else res.median_x2 = 49'(vals[n/2-1] + vals[n/2]);
    end
    // Rate walk back from the newest finished bucket.
    if (win != 0) begin
      bsum = 0;
      dsum = 0;
      idx  = head - 6'd1;
      for (int i = 0; i < Depth; i++) begin
        bsum += ring_bytes[idx];
        dsum += resolve_time(ring_time[idx]);
        if (dsum >= win) break;
        idx = idx - 6'd1;
      end
      d = (win > dsum) ? win : dsum;
      q = bsum / d;
      r = bsum % d;
      if (q > RateMax / 1000000) res.rate_bps = RateMax;
      else begin
        hi = q * 1000000;
        lo = (r * 1000000) / d;
        res.rate_bps = (hi + lo > RateMax) ? RateMax : 56'(hi + lo);
      end
    end
    return res;
  endfunction

  // Apply one accepted transaction to the predictor.
  task automatic apply_item(logic [1:0] cmd, logic [31:0] bc, logic [31:0] el,
                            logic [31:0] win, logic skip);
    logic [48:0] acc;
    case (cmd)
      swts_pkg::CMD_ADD: begin
        acc = ring_bytes[head] + bc;
        ring_bytes[head] = (acc > BytesMax) ? BytesMax : acc[47:0];
      end
      swts_pkg::CMD_TICK: begin
        ring_time[head] = resolve_time(el);
        head = head + 6'd1;
        ring_bytes[head] = '0;
        ring_time[head] = '0;
      end
      swts_pkg::CMD_QUERY: begin
        pending_stats.insert(pending_stats.size(), compute_stats(win, skip));
        queries_sent++;
      end
      default: ;
    endcase
  endtask

  // Send one transaction; called and returns at a falling edge.
  task automatic send_item(logic [1:0] cmd, logic [31:0] bc, logic [31:0] el,
                           logic [31:0] win, logic skip);
    while (!no_idle && $urandom_range(99) < IdlePct) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid       = 1'b1;
    in_if.cmd         = cmd;
    in_if.byte_count  = bc;
    in_if.elapsed_us  = el;
    in_if.window_us   = win;
    in_if.skip_zeroes = skip;
    do @(posedge clk_i); while (!in_if.ready);
    apply_item(cmd, bc, el, win, skip);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Wait until all results are in and the block has settled.
  task automatic drain();
    in_if.valid = 1'b0;
    while (pending_stats.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_interval(logic [31:0] value);
    drain();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    interval    = value;
  endtask

  // Result receiver with random stalls and an optional long hold-off.
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_if.ready <= 1'b0;
      hold_cycles  <= hold_cycles - 1;
    end else begin
      out_if.ready <= no_idle || ($urandom_range(99) >= IdlePct);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    stats_t exp_s, got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = '{out_if.rate_bps, out_if.max_bytes, out_if.min_bytes,
              out_if.mean_q8, out_if.median_x2};
      if (pending_stats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transaction: %p", got);
      end else begin
        exp_s = pending_stats.pop_front();
        stats_checked++;
        if (got !== exp_s) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch on result %0d:", stats_checked);
            $display("  rate   exp %0d got %0d", exp_s.rate_bps, got.rate_bps);
            $display("  max    exp %0d got %0d", exp_s.max_bytes, got.max_bytes);
            $display("  min    exp %0d got %0d", exp_s.min_bytes, got.min_bytes);
            $display("  mean   exp %0d got %0d", exp_s.mean_q8, got.mean_q8);
            $display("  median exp %0d got %0d", exp_s.median_x2, got.median_x2);
          end
        end
      end
    end
  end

  // Corner cases: empty ring, unused command, field extremes.
  task automatic test_directed();
    send_item(swts_pkg::CMD_QUERY, 0, 0, 0, 1'b0);
    send_item(swts_pkg::CMD_QUERY, 0, 0, 32'hFFFF_FFFF, 1'b1);
    send_item(CmdUnused, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_item(swts_pkg::CMD_ADD, 32'hFFFF_FFFF, 0, 0, 1'b0);
    send_item(swts_pkg::CMD_ADD, 1, 0, 0, 1'b0);
    send_item(swts_pkg::CMD_TICK, 0, 0, 0, 1'b0);
    send_item(swts_pkg::CMD_QUERY, 0, 0, 1, 1'b1);
    send_item(swts_pkg::CMD_ADD, 1500, 0, 0, 1'b0);
    send_item(swts_pkg::CMD_TICK, 0, 32'hFFFF_FFFF, 0, 1'b0);
    send_item(swts_pkg::CMD_TICK, 0, 1, 0, 1'b0);
    send_item(swts_pkg::CMD_QUERY, 0, 0, 32'hFFFF_FFFF, 1'b0);
    send_item(swts_pkg::CMD_QUERY, 0, 0, 32'hFFFF_FFFF, 1'b1);
    send_item(swts_pkg::CMD_ADD, 0, 0, 0, 1'b0);
    send_item(swts_pkg::CMD_ADD, 7, 0, 0, 1'b1);
    send_item(swts_pkg::CMD_TICK, 32'hFFFF_FFFF, 1000, 32'hFFFF_FFFF, 1'b1);
    send_item(swts_pkg::CMD_QUERY, 0, 0, 2000, 1'b0);
    send_item(swts_pkg::CMD_QUERY, 0, 0, 500, 1'b1);
    // Wrap the head around the whole ring.
    for (int i = 0; i < 66; i++) send_item(swts_pkg::CMD_TICK, 0, i[0] ? 0 : 10, 0, 1'b0);
    send_item(swts_pkg::CMD_QUERY, 0, 0, 32'hFFFF_FFFF, 1'b0);
    send_item(swts_pkg::CMD_QUERY, 0, 0, 32'hFFFF_FFFF, 1'b1);
  endtask

  // Fill one bucket far enough that a one-microsecond window saturates the rate.
  task automatic test_saturation();
    no_idle = 1'b1;
    for (int i = 0; i < 20; i++) send_item(swts_pkg::CMD_ADD, 32'hFFFF_FFFF, 0, 0, 1'b0);
    send_item(swts_pkg::CMD_TICK, 0, 1, 0, 1'b0);
    send_item(swts_pkg::CMD_QUERY, 0, 0, 1, 1'b0);
    send_item(swts_pkg::CMD_QUERY, 0, 0, 32'hFFFF_FFFF, 1'b1);
    no_idle = 1'b0;
  endtask

  // Hold off the receiver while the sender keeps offering transactions.
  task automatic test_backpressure();
    drain();
    hold_cycles = 20000;
    send_item(swts_pkg::CMD_QUERY, 0, 0, 5000, 1'b0);
    for (int i = 0; i < 6; i++) send_item(swts_pkg::CMD_ADD, $urandom, 0, 0, 1'b0);
    send_item(swts_pkg::CMD_QUERY, 0, 0, 5000, 1'b1);
  endtask

  // Random traffic: mostly adds and ticks, with occasional queries.
  task automatic test_random(int unsigned count);
    int unsigned sel;
    logic [31:0] bc, el, win;
    logic        sk;
    for (int unsigned i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      sk  = 1'($urandom_range(1));
      case ($urandom_range(2))
        0: bc = $urandom;
        1: bc = $urandom_range(1500);
        default: bc = ($urandom_range(3) == 0) ? 0 : $urandom_range(65535);
      endcase
      case ($urandom_range(3))
        0, 1: el = 0;
        2: el = $urandom_range(5000);
        default: el = $urandom;
      endcase
      case ($urandom_range(4))
        0: win = 0;
        1: win = $urandom_range(5000);
        2: win = $urandom_range(200000);
        default: win = $urandom;
      endcase
      if (sel < 55) send_item(swts_pkg::CMD_ADD, bc, el, win, sk);
      else if (sel < 88) send_item(swts_pkg::CMD_TICK, bc, el, win, sk);
      else if (sel < 94) send_item(swts_pkg::CMD_QUERY, bc, el, win, sk);
      else send_item(CmdUnused, bc, el, win, sk);
    end
  endtask

  // Several tick interval settings, extremes included.
  task automatic test_config_phases();
    write_interval(32'd1);
    test_random(210);
    write_interval(32'hFFFF_FFFF);
    no_idle = 1'b1;
    test_random(210);
    no_idle = 1'b0;
    write_interval(32'd0);
    test_random(110);
    write_interval($urandom);
    test_random(110);
    write_interval(32'd1000);
    test_random(200);
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    in_if.valid       = 1'b0;
    in_if.cmd         = swts_pkg::CMD_ADD;
    in_if.byte_count  = '0;
    in_if.elapsed_us  = '0;
    in_if.window_us   = '0;
    in_if.skip_zeroes = 1'b0;
    out_if.ready      = 1'b0;
    no_idle           = 1'b0;
    hold_cycles       = 0;
    mismatches        = 0;
    queries_sent      = 0;
    stats_checked     = 0;
    items_sent        = 0;
    cycles            = 0;
    head              = '0;
    interval          = swts_pkg::TickReset;
    for (int i = 0; i < Depth; i++) begin
      ring_bytes[i] = '0;
      ring_time[i]  = '0;
    end
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_saturation();
    test_backpressure();
    test_config_phases();

    drain();
    repeat (50) @(negedge clk_i);
    $display("Sent %0d transactions including %0d queries over %0d cycles.",
             items_sent, queries_sent, cycles);
    $display("Checked %0d statistics results, %0d mismatches.", stats_checked, mismatches);
    if (mismatches == 0 && pending_stats.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/swts_pkg.sv
hw/rtl/swts_in_if.sv
hw/rtl/swts_out_if.sv
hw/rtl/swts_div.sv
hw/rtl/sliding_window_traffic_stats.sv
tb/sv/tb_sliding_window_traffic_stats.sv
